// ===== rtl/irc_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_pkg
// shared types and codes of the invalidation range coalescer
// ----------------------------------------------------------------------------
package irc_pkg;

    // fixed field widths
    localparam int FIELD_W    = 48;
    localparam int MODE_W     = 2;
    localparam int ACT_W      = 2;
    localparam int GAP_W      = 16;
    localparam int DEPTH_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP = 1'd1;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd4096;

    // input modes
    localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EXEC  = 2'd3;

    // result actions
    localparam logic [ACT_W-1:0] ACT_INVALIDATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_EN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EXEC_EN    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNDERFLOW  = 2'd3;

    // result source select
    localparam int SEL_W = 2;
    localparam logic [SEL_W-1:0] SEL_FLAG  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_RANGE = 2'd1;
    localparam logic [SEL_W-1:0] SEL_ENTRY = 2'd2;

    typedef struct packed {
        logic             load;
        logic             depth_inc;
        logic             depth_dec;
        logic             rd_start;
        logic             rd_issue;
        logic             rd_next;
        logic             merge_wr;
        logic             append;
        logic             clear_count;
        logic             emit;
        logic [SEL_W-1:0] emit_sel;
        logic [ACT_W-1:0] emit_action;
        logic             emit_last;
    } irc_cmd_t;

    typedef struct packed {
        logic depth_zero;
        logic depth_one;
        logic depth_max;
        logic count_zero;
        logic count_full;
        logic data_ok;
        logic merge_hit;
        logic at_last;
        logic out_free;
        logic wx;
    } irc_stat_t;

endpackage

// ===== rtl/irc_in_if.sv =====
// ----------------------------------------------------------------------------
// irc_in_if
// event channel: mode and address range
// ----------------------------------------------------------------------------
interface irc_in_if import irc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_end;

    modport source (output valid, output mode, output range_start, output range_end,
                    input ready);
    modport sink   (input valid, input mode, input range_start, input range_end,
                    output ready);

endinterface

// ===== rtl/irc_out_if.sv =====
// ----------------------------------------------------------------------------
// irc_out_if
// result channel: action, range and last flag
// ----------------------------------------------------------------------------
interface irc_out_if import irc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [FIELD_W-1:0] inv_start;
    logic [FIELD_W-1:0] inv_length;
    logic               last;

    modport source (output valid, output action, output inv_start, output inv_length,
                    output last, input ready);
    modport sink   (input valid, input action, input inv_start, input inv_length,
                    input last, output ready);

endinterface

// ===== rtl/irc_ram.sv =====
// ----------------------------------------------------------------------------
// irc_ram
// single-port-write, single-port-read RAM with registered read data
// ----------------------------------------------------------------------------
module irc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/irc_dp.sv =====
// ----------------------------------------------------------------------------
// irc_dp
// datapath: config, depth, pending table, merge compare, result register
// ----------------------------------------------------------------------------
module irc_dp import irc_pkg::*; #(
    parameter int ENTRIES   = 32,
    parameter int ADDR_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  irc_cmd_t              cmd,
    output irc_stat_t             stat,
    input  logic [FIELD_W-1:0]    range_start,
    input  logic [FIELD_W-1:0]    range_end,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [ACT_W-1:0]      action,
    output logic [FIELD_W-1:0]    inv_start,
    output logic [FIELD_W-1:0]    inv_length,
    output logic                  last
);

    localparam int STORE_W = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    logic                  wx_reg;
    logic [GAP_W-1:0]      gap_reg;
    logic [STORE_W-1:0]    lo_reg;
    logic [STORE_W-1:0]    hi_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [IDX_W-1:0]      rd_ptr_reg;
    logic                  data_ok_reg;
    logic                  out_valid_reg;
    logic [ACT_W-1:0]      action_reg;
    logic [FIELD_W-1:0]    start_reg;
    logic [FIELD_W-1:0]    length_reg;
    logic                  last_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [2*STORE_W-1:0]  ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [2*STORE_W-1:0]  ram_rdata;
    logic [STORE_W-1:0]    q_lo;
    logic [STORE_W-1:0]    q_hi;
    logic [STORE_W:0]      q_hi_gap;
    logic [STORE_W:0]      hi_gap;
    logic [STORE_W-1:0]    mrg_lo;
    logic [STORE_W-1:0]    mrg_hi;
    logic [IDX_W-1:0]      rd_ptr_inc;
    logic [STORE_W-1:0]    src_lo;
    logic [STORE_W-1:0]    src_hi;
    logic                  out_free;

    // pending table, one row holds {high, low}
    irc_ram #(
        .WIDTH (2 * STORE_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_lo       = ram_rdata[STORE_W-1:0];
    assign q_hi       = ram_rdata[2*STORE_W-1:STORE_W];
    assign rd_ptr_inc = IDX_W'(rd_ptr_reg + IDX_W'(1));

    // exact merge test, one extra bit so the gap never wraps
    assign q_hi_gap = {1'b0, q_hi} + (STORE_W + 1)'(gap_reg);
    assign hi_gap   = {1'b0, hi_reg} + (STORE_W + 1)'(gap_reg);
    assign mrg_lo   = (lo_reg < q_lo) ? lo_reg : q_lo;
    assign mrg_hi   = (hi_reg > q_hi) ? hi_reg : q_hi;

    assign ram_re    = cmd.rd_issue | cmd.rd_next;
    assign ram_raddr = cmd.rd_next ? rd_ptr_inc : rd_ptr_reg;
    assign ram_we    = cmd.merge_wr | cmd.append;
    assign ram_waddr = cmd.merge_wr    ? rd_ptr_reg :
                       cmd.clear_count ? '0 : cnt_reg[IDX_W-1:0];
    assign ram_wdata = cmd.merge_wr ? {mrg_hi, mrg_lo} : {hi_reg, lo_reg};

    assign cnt_next = (cmd.clear_count ? '0 : cnt_reg) + CNT_W'(cmd.append);

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.depth_zero = (depth_reg == '0);
        stat.depth_one  = (depth_reg == DEPTH_W'(1));
        stat.depth_max  = (depth_reg == DEPTH_MAX);
        stat.count_zero = (cnt_reg == '0);
        stat.count_full = (cnt_reg == CNT_W'(ENTRIES));
        stat.data_ok    = data_ok_reg;
        stat.merge_hit  = ({1'b0, lo_reg} <= q_hi_gap) && (hi_gap >= {1'b0, q_lo});
        stat.at_last    = ((CNT_W'(rd_ptr_reg) + CNT_W'(1)) == cnt_reg);
        stat.out_free   = out_free;
        stat.wx         = wx_reg;
    end

    always_comb
    begin
        if (cmd.emit_sel == SEL_ENTRY)
        begin
            src_lo = q_lo;
            src_hi = q_hi;
        end
        else
        begin
            src_lo = lo_reg;
            src_hi = hi_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg        <= 1'b1;
            gap_reg       <= GAP_RESET;
            depth_reg     <= '0;
            cnt_reg       <= '0;
            rd_ptr_reg    <= '0;
            data_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WX:  wx_reg  <= cfg_data[0];
                    CFG_GAP: gap_reg <= cfg_data[GAP_W-1:0];
                endcase
            end
            if (cmd.depth_inc)
            begin
                depth_reg <= depth_reg + DEPTH_W'(1);
            end
            else if (cmd.depth_dec)
            begin
                depth_reg <= depth_reg - DEPTH_W'(1);
            end
            if (cmd.clear_count || cmd.append)
            begin
                cnt_reg <= cnt_next;
            end
            if (cmd.rd_start)
            begin
                rd_ptr_reg  <= '0;
                data_ok_reg <= 1'b0;
            end
            else if (cmd.rd_issue)
            begin
                data_ok_reg <= 1'b1;
            end
            else if (cmd.rd_next)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg <= range_start[STORE_W-1:0];
            hi_reg <= range_end[STORE_W-1:0];
        end
        if (cmd.emit)
        begin
            action_reg <= cmd.emit_action;
            last_reg   <= cmd.emit_last;
            if (cmd.emit_sel == SEL_FLAG)
            begin
                start_reg  <= '0;
                length_reg <= '0;
            end
            else
            begin
                start_reg  <= FIELD_W'(src_lo);
                length_reg <= FIELD_W'(src_hi) - FIELD_W'(src_lo);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign inv_start  = start_reg;
    assign inv_length = length_reg;
    assign last       = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while a result still waits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("pending count beyond table size");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (cmd.clear_count || cnt_reg < CNT_W'(ENTRIES)))
        else $error("append into a full table");

    a_merge_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_wr |-> data_ok_reg)
        else $error("merge written without table data");

endmodule

// ===== rtl/irc_ctrl.sv =====
// ----------------------------------------------------------------------------
// irc_ctrl
// controller: decodes events and sequences scan, drain and result transfers
// ----------------------------------------------------------------------------
module irc_ctrl import irc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    output logic              in_ready,
    input  irc_stat_t         stat,
    output irc_cmd_t          cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             exec_after_reg;
    logic             exec_after_next;
    logic             append_after_reg;
    logic             append_after_next;
    logic [ACT_W-1:0] act_reg;
    logic [ACT_W-1:0] act_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        exec_after_next   = exec_after_reg;
        append_after_next = append_after_reg;
        act_next          = act_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (in_mode)
                        MODE_OPEN:
                        begin
                            if (!stat.depth_max)
                            begin
                                cmd.depth_inc = 1'b1;
                                if (stat.depth_zero && stat.wx)
                                begin
                                    act_next   = ACT_WRITE_EN;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        MODE_CLOSE:
                        begin
                            if (stat.depth_zero)
                            begin
                                act_next   = ACT_UNDERFLOW;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                cmd.depth_dec = 1'b1;
                                if (stat.depth_one)
                                begin
                                    if (!stat.count_zero)
                                    begin
                                        cmd.rd_start      = 1'b1;
                                        exec_after_next   = stat.wx;
                                        append_after_next = 1'b0;
                                        state_next        = ST_DRAIN;
                                    end
                                    else if (stat.wx)
                                    begin
                                        act_next   = ACT_EXEC_EN;
                                        state_next = ST_EMIT;
                                    end
                                end
                            end
                        end
                        MODE_RANGE:
                        begin
                            if (stat.depth_zero)
                            begin
                                act_next   = ACT_INVALIDATE;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        MODE_EXEC:
                        begin
                            if (stat.depth_zero && stat.wx)
                            begin
                                act_next   = ACT_EXEC_EN;
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (stat.count_zero)
                begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!stat.data_ok)
                begin
                    cmd.rd_issue = 1'b1;
                end
                else if (stat.merge_hit)
                begin
                    cmd.merge_wr = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (!stat.at_last)
                begin
                    cmd.rd_next = 1'b1;
                end
                else if (stat.count_full)
                begin
                    cmd.rd_start      = 1'b1;
                    exec_after_next   = 1'b0;
                    append_after_next = 1'b1;
                    state_next        = ST_DRAIN;
                end
                else
                begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DRAIN:
            begin
                if (!stat.data_ok)
                begin
                    cmd.rd_issue = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = SEL_ENTRY;
                    cmd.emit_action = ACT_INVALIDATE;
                    cmd.emit_last   = stat.at_last && !exec_after_reg;
                    if (!stat.at_last)
                    begin
                        cmd.rd_next = 1'b1;
                    end
                    else
                    begin
                        cmd.clear_count = 1'b1;
                        cmd.append      = append_after_reg;
                        if (exec_after_reg)
                        begin
                            act_next   = ACT_EXEC_EN;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = (act_reg == ACT_INVALIDATE) ? SEL_RANGE : SEL_FLAG;
                    cmd.emit_action = act_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            exec_after_reg   <= 1'b0;
            append_after_reg <= 1'b0;
            act_reg          <= ACT_INVALIDATE;
        end
        else
        begin
            state_reg        <= state_next;
            exec_after_reg   <= exec_after_next;
            append_after_reg <= append_after_next;
            act_reg          <= act_next;
        end
    end

endmodule

// ===== rtl/invalidation_range_coalescer_unit.sv =====
// a single-result event passes through the emit state into the result register;
//   a range inside a window scans the pending entries in turn, plus a drain when full
// a drain reads the N pending ranges in table order (one table read per cycle while the
//   result register is free) and sends one invalidate result per range
// throughput: one event at a time; the table read port sets the pace of scan and drain
// reset: depth and pending count cleared, wx_supported = 1, merge_gap = 4096
// ----------------------------------------------------------------------------
// invalidation_range_coalescer_unit
// tracks write-window nesting and coalesces instruction-cache invalidation
// ranges requested inside a window, flushing them when the last window closes
// ----------------------------------------------------------------------------
module invalidation_range_coalescer_unit import irc_pkg::*; #(
    parameter int ENTRIES   = 32,
    parameter int ADDR_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    irc_in_if.sink                in_ch,
    irc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // command and status between controller and datapath
    irc_cmd_t  cmd;
    irc_stat_t stat;

    // controller: event decode, table scan for merges, drain sequencing,
    // and single-result transfers (write enable, execute enable, underflow,
    // direct range outside a window)
    irc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: config registers, window depth, pending table in RAM,
    // merge compare and the result register that parts the two channels
    irc_dp #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .range_start (in_ch.range_start),
        .range_end   (in_ch.range_end),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .action      (out_ch.action),
        .inv_start   (out_ch.inv_start),
        .inv_length  (out_ch.inv_length),
        .last        (out_ch.last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the invalidation range coalescer: a queue-fed
// driver sends window, range and execute calls, a predictor of the window
// depth and the pending range table works out the actions each call causes,
// and a monitor compares every action transfer with the oldest prediction
// ----------------------------------------------------------------------------
module tb;
    import irc_pkg::*;

    localparam int TABLE_SLOTS = 32;        // pending table depth of the block
    localparam int SETTLE      = 48;        // worst drain plus margin
    localparam int CYCLE_LIMIT = 2000000;   // hard stop for a hung run
    localparam int IDLE_PCT    = 38;

    // one call into the block
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
    } cache_op_t;

    // one action out of the block
    typedef struct {
        logic [ACT_W-1:0]   act;
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] len;
        logic               last;
    } action_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    irc_in_if  in_ch ();
    irc_out_if out_ch ();

    invalidation_range_coalescer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // calls waiting to be sent, and the one on the bus
    cache_op_t op_q[$];
    cache_op_t op_cur;

    // predicted actions, oldest first
    action_t expected_actions[$];
    action_t step_actions[$];
    action_t want_r;

    // predictor copy of the configuration and state
    logic                  wx_on     = 1'b1;
    logic [GAP_W-1:0]      gap_bytes = GAP_RESET;
    logic [DEPTH_W-1:0]    win_depth = '0;
    int                    tab_count = 0;
    logic [FIELD_W-1:0]    tab_lo[TABLE_SLOTS];
    logic [FIELD_W-1:0]    tab_hi[TABLE_SLOTS];

    // stimulus bookkeeping: depth as the generator sees it
    int gen_depth = 0;
    int gen_items = 0;

    int idle_pct  = IDLE_PCT;
    int fail_cnt  = 0;
    int cycle_cnt = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic void push_action(logic [ACT_W-1:0] a, logic [FIELD_W-1:0] s,
                                        logic [FIELD_W-1:0] l);
        action_t r;
        r.act  = a;
        r.addr = s;
        r.len  = l;
        r.last = 1'b0;
        step_actions.push_back(r);
    endfunction

    // every pending range goes out in table order, length wraps mod 2^48
    function automatic void flush_table();
        for (int i = 0; i < tab_count; i++)
            push_action(ACT_INVALIDATE, tab_lo[i], tab_hi[i] - tab_lo[i]);
        tab_count = 0;
    endfunction

    function automatic void predict_actions(cache_op_t op);
        logic [63:0] lo_x;
        logic [63:0] hi_x;
        logic [63:0] gap_x;
        bit          hit;
        action_t     r;
        lo_x  = 64'(op.lo);
        hi_x  = 64'(op.hi);
        gap_x = 64'(gap_bytes);
        hit   = 1'b0;
        case (op.mode)
            MODE_OPEN:
            begin
                // depth saturates, only the first open toggles write enable
                if (win_depth != DEPTH_MAX)
                begin
                    win_depth++;
                    if (win_depth == 1 && wx_on)
                        push_action(ACT_WRITE_EN, '0, '0);
                end
            end
            MODE_CLOSE:
            begin
                if (win_depth == 0)
                    push_action(ACT_UNDERFLOW, '0, '0);
                else
                begin
                    win_depth--;
                    if (win_depth == 0)
                    begin
                        flush_table();
                        if (wx_on)
                            push_action(ACT_EXEC_EN, '0, '0);
                    end
                end
            end
            MODE_RANGE:
            begin
                if (win_depth == 0)
                    push_action(ACT_INVALIDATE, op.lo, op.hi - op.lo);
                else
                begin
                    // first entry within the gap absorbs the range, no wrap in the test
                    for (int i = 0; i < tab_count && !hit; i++)
                    begin
                        if (lo_x <= 64'(tab_hi[i]) + gap_x && hi_x + gap_x >= 64'(tab_lo[i]))
                        begin
                            if (op.lo < tab_lo[i])
                                tab_lo[i] = op.lo;
                            if (op.hi > tab_hi[i])
                                tab_hi[i] = op.hi;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                    begin
                        if (tab_count >= TABLE_SLOTS)
                            flush_table();
                        tab_lo[tab_count] = op.lo;
                        tab_hi[tab_count] = op.hi;
                        tab_count++;
                    end
                end
            end
            default:
            begin
                if (win_depth == 0 && wx_on)
                    push_action(ACT_EXEC_EN, '0, '0);
            end
        endcase
        // last flag on the final action of this call
        if (step_actions.size() != 0)
        begin
            r = step_actions.pop_back();
            r.last = 1'b1;
            step_actions.push_back(r);
        end
        while (step_actions.size() != 0)
            expected_actions.push_back(step_actions.pop_front());
    endfunction

    // ------------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------------

    function automatic logic [FIELD_W-1:0] rand48();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    function automatic logic [FIELD_W-1:0] rand_addr(logic [FIELD_W-1:0] base);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return rand48();
            default: return base + FIELD_W'($urandom_range(0, 'h3ffff));
        endcase
    endfunction

    function automatic void post_op(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] lo,
                                    logic [FIELD_W-1:0] hi);
        cache_op_t op;
        op.mode = m;
        op.lo   = lo;
        op.hi   = hi;
        op_q.push_back(op);
        gen_items++;
        if (m == MODE_OPEN && gen_depth < 255)
            gen_depth++;
        else if (m == MODE_CLOSE && gen_depth > 0)
            gen_depth--;
    endfunction

    // open, a run of ranges with some nesting and execute calls, close;
    // spread ranges are far apart so that they fill the table
    function automatic void window_burst(int n_ranges, bit spread);
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        int                 roll;
        bit                 inner;
        case ($urandom_range(0, 7))
            0:       base = 48'hffff_fffc_0000;   // near the top, ranges wrap
            1:       base = '0;
            default: base = rand48();
        endcase
        inner = 1'b0;
        post_op(MODE_OPEN, rand48(), rand48());
        for (int k = 0; k < n_ranges; k++)
        begin
            roll = $urandom_range(0, 99);
            if (!spread && roll < 8)
            begin
                post_op(inner ? MODE_CLOSE : MODE_OPEN, rand48(), rand48());
                inner = !inner;
            end
            else if (!spread && roll < 14)
                post_op(MODE_EXEC, rand48(), rand48());
            if (spread)
                lo = base + FIELD_W'(k) * 48'h40000 + FIELD_W'($urandom_range(0, 'hfff));
            else
                lo = base + FIELD_W'($urandom_range(0, 'h3ffff));
            roll = $urandom_range(0, 99);
            if (spread || roll < 80)
                hi = lo + FIELD_W'($urandom_range(0, 'h2fff));
            else if (roll < 90)
                hi = lo - FIELD_W'($urandom_range(1, 'hfff));   // reversed range
            else
                hi = rand48();
            post_op(MODE_RANGE, lo, hi);
        end
        if (inner)
            post_op(MODE_CLOSE, rand48(), rand48());
        post_op(MODE_CLOSE, rand48(), rand48());
    endfunction

    // mostly well-formed windows, some table overflows, some stray calls
    function automatic void random_phase(int budget);
        int                 stop;
        int                 roll;
        logic [FIELD_W-1:0] base;
        stop = gen_items + budget;
        while (gen_items < stop)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                window_burst($urandom_range(0, 10), 1'b0);
            else if (roll < 75)
                window_burst($urandom_range(33, 40), 1'b1);
            else
            begin
                base = rand48();
                repeat ($urandom_range(1, 4))
                    post_op(MODE_W'($urandom_range(0, 3)), rand_addr(base), rand_addr(base));
            end
        end
        // bring the depth back to zero before any register write
        while (gen_depth > 0)
            post_op(MODE_CLOSE, rand48(), rand48());
    endfunction

    // ------------------------------------------------------------------------
    // phase control
    // ------------------------------------------------------------------------

    // block idle: nothing queued, nothing on the bus, nothing predicted
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (op_q.size() != 0 || in_ch.valid || expected_actions.size() != 0);
        // a merge scan may still run with no action pending
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_WX)
            wx_on = val[0];
        else
            gap_bytes = val;
    endtask

    task automatic set_config(logic wx, logic [GAP_W-1:0] gap);
        write_reg(CFG_WX, CFG_DATA_W'(wx));
        write_reg(CFG_GAP, gap);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed calls at reset configuration
        post_op(MODE_CLOSE, '0, '0);                           // underflow at depth zero
        post_op(MODE_EXEC, '1, '1);                            // execute enable outside window
        post_op(MODE_RANGE, '0, '1);                           // full-width length
        post_op(MODE_RANGE, '1, '0);                           // reversed, wraps to one
        post_op(MODE_RANGE, '0, '0);                           // empty range
        post_op(MODE_OPEN, '0, '0);                            // write enable
        post_op(MODE_OPEN, '1, '1);                            // nested open, silent
        post_op(MODE_EXEC, '0, '0);                            // execute inside window, silent
        post_op(MODE_RANGE, 48'h1000, 48'h2000);
        post_op(MODE_RANGE, 48'h2800, 48'h3000);               // merges from above
        post_op(MODE_RANGE, 48'h0000, 48'h0100);               // merges from below
        post_op(MODE_RANGE, 48'h5000, 48'h5100);               // just beyond the gap
        post_op(MODE_RANGE, 48'h4000, 48'h4010);               // exactly on the gap edge
        post_op(MODE_RANGE, '1, 48'h10);                       // reversed range stored
        post_op(MODE_RANGE, 48'h8000_0000_0000, 48'h7fff_ffff_ffff);
        post_op(MODE_CLOSE, '0, '0);                           // inner close, silent
        post_op(MODE_CLOSE, '0, '0);                           // drain then execute enable
        post_op(MODE_CLOSE, '0, '0);
        post_op(MODE_RANGE, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555);
        post_op(MODE_RANGE, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa);

        // full table: overflow drain on the range past the last slot
        window_burst(33, 1'b1);
        random_phase(25);
        wait_quiet();

        // no toggle, zero gap
        set_config(1'b0, '0);
        random_phase(25);
        wait_quiet();

        // widest gap, both sides without idling, close with every slot taken
        idle_pct = 0;
        set_config(1'b1, '1);
        window_burst(32, 1'b1);
        random_phase(25);
        wait_quiet();

        idle_pct = IDLE_PCT;
        set_config(1'b0, GAP_W'($urandom_range(1, 'hfffe)));
        random_phase(12);
        wait_quiet();

        set_config(1'b1, GAP_RESET);
        random_phase(12);
        wait_quiet();

        if (fail_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: presents queued calls, predicts on each transfer
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.mode        <= '0;
            in_ch.range_start <= '0;
            in_ch.range_end   <= '0;
        end
        else
        begin
            // transfer of the call on the bus
            if (in_ch.valid && in_ch.ready)
                predict_actions(op_cur);
            // bus free: next call, or a random gap
            if (!in_ch.valid || in_ch.ready)
            begin
                if (op_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    op_cur = op_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.mode        <= op_cur.mode;
                    in_ch.range_start <= op_cur.lo;
                    in_ch.range_end   <= op_cur.hi;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, checks every action transfer
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_actions.size() == 0)
                begin
                    $error("unexpected action transfer: action %0d start %h length %h",
                           out_ch.action, out_ch.inv_start, out_ch.inv_length);
                    fail_cnt++;
                end
                else
                begin
                    want_r = expected_actions.pop_front();
                    check_field("action", FIELD_W'(want_r.act), FIELD_W'(out_ch.action));
                    check_field("inv_start", want_r.addr, out_ch.inv_start);
                    check_field("inv_length", want_r.len, out_ch.inv_length);
                    check_field("last", FIELD_W'(want_r.last), FIELD_W'(out_ch.last));
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // hung-run guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule
